FILE: hdl/aps_pkg.sv
package aps_pkg;

  // Default sizing, handed down through the top-level parameters
  localparam int MAX_ALARMS_DEF   = 8;
  localparam int HANDLER_BITS_DEF = 8;
  localparam int HANDLER_WIDE     = 16;

  // Command actions
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ADD_OK = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  typedef struct packed {
    logic        action;
    logic [31:0] delay;
    logic [7:0]  handler_id;
    logic [15:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_handler;
    logic [3:0] active_count;
    logic       last;
  } res_t;

  // Per-cycle control shared by every cell of the chain
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

endpackage

FILE: hdl/aps_cell.sv
module aps_cell #(
  parameter int HANDLER_BITS = aps_pkg::HANDLER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  aps_pkg::cell_ctl_t      ctl,
  input  logic                    hole_in,
  output logic                    hole_out,
  input  logic                    prev_valid,
  input  logic [31:0]             prev_deadline,
  input  logic [HANDLER_BITS-1:0] prev_handler,
  input  logic                    next_valid,
  input  logic [31:0]             next_deadline,
  input  logic [HANDLER_BITS-1:0] next_handler,
  output logic                    valid,
  output logic [31:0]             deadline,
  output logic [HANDLER_BITS-1:0] handler
);
  import aps_pkg::*;

  logic take_prev;

  // Shift down on insert only up to and including the first empty cell
  assign take_prev = ctl.insert && !hole_in;
  assign hole_out  = hole_in || !valid;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_prev) begin
      valid <= prev_valid;
    end else if (ctl.rotate) begin
      valid <= next_valid;
    end
  end

  // Alarm payload
  always_ff @(posedge clk) begin
    if (take_prev) begin
      deadline <= prev_deadline;
      handler  <= prev_handler;
    end else if (ctl.rotate) begin
      deadline <= next_deadline;
      handler  <= next_handler;
    end
  end

endmodule

FILE: hdl/alarm_pool_scheduler.sv
// Alarm pool scheduler.
// Command channel: a command beat is taken at a rising edge with start high and
// busy low. An add command stores an alarm due at time + delay; a tick command
// advances time by elapsed and fires every due alarm, newest first.
// Result channel: each result beat sits on result for one cycle with done high.
// The receiver cannot stall; every beat must be taken when shown.
// Flow: an add answers in the cycle after it is taken and leaves busy low,
// so adds may follow every cycle. A tick advances time at the edge that takes
// it, then holds busy while the alarm chain rotates cell by cell past the
// single deadline comparator at its head, and while it closes. The closing
// beat shows in the same cycle that busy falls, so the next command can be
// taken while it shows, but not before. Fired beats appear during the
// rotation, each one held back until the next is found, so the final one
// carries last.
// A tick gives one result beat per fired alarm, or one "none" beat.
// Reset (rst, synchronous) clears time and the alarm count and empties all cells.
module alarm_pool_scheduler #(
  parameter int MAX_ALARMS   = aps_pkg::MAX_ALARMS_DEF,
  parameter int HANDLER_BITS = aps_pkg::HANDLER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  aps_pkg::cmd_t command,
  output logic          done,
  output aps_pkg::res_t result
);
  import aps_pkg::*;

  localparam int COUNT_W = $clog2(MAX_ALARMS + 1);
  localparam int STEP_W  = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]              state;
  logic [31:0]             cur_time;
  logic [COUNT_W-1:0]      pending;
  logic [STEP_W-1:0]       step;
  logic                    held_valid;
  logic [HANDLER_BITS-1:0] held_handler;
  logic [COUNT_W-1:0]      held_count;

  logic                    accept;
  logic                    pool_full;
  logic                    expire;
  logic [COUNT_W-1:0]      pending_dec;
  logic [31:0]             new_deadline;
  logic [HANDLER_WIDE-1:0] hid_wide;
  logic [HANDLER_WIDE-1:0] held_wide;
  logic [HANDLER_WIDE-1:0] zero_cnt_dummy;
  cell_ctl_t               ctl;

  logic                    c_valid    [MAX_ALARMS];
  logic [31:0]             c_deadline [MAX_ALARMS];
  logic [HANDLER_BITS-1:0] c_handler  [MAX_ALARMS];
  logic                    hole       [MAX_ALARMS+1];

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign pool_full    = (pending == COUNT_W'(MAX_ALARMS));
  assign pending_dec  = pending - COUNT_W'(1);
  assign new_deadline = cur_time + command.delay;
  assign hid_wide     = HANDLER_WIDE'(command.handler_id);
  assign held_wide    = HANDLER_WIDE'(held_handler);
  assign zero_cnt_dummy = '0;

  // Head of the chain decides; a due alarm leaves, others rotate to the tail
  assign expire = c_valid[0] && (c_deadline[0] <= cur_time);

  assign ctl.insert = accept && (command.action == ACT_ADD) && !pool_full;
  assign ctl.rotate = (state == ST_WALK);

  assign hole[0] = 1'b0;

  // Chain of alarm cells, newest in cell 0
  for (genvar i = 0; i < MAX_ALARMS; i++) begin : g_cell
    logic                    pv;
    logic [31:0]             pd;
    logic [HANDLER_BITS-1:0] ph;
    logic                    nv;
    logic [31:0]             nd;
    logic [HANDLER_BITS-1:0] nh;

    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pd = new_deadline;
      assign ph = hid_wide[HANDLER_BITS-1:0];
    end else begin : g_body
      assign pv = c_valid[i-1];
      assign pd = c_deadline[i-1];
      assign ph = c_handler[i-1];
    end

    if (i == MAX_ALARMS - 1) begin : g_tail
      assign nv = c_valid[0] && !expire;
      assign nd = c_deadline[0];
      assign nh = c_handler[0];
    end else begin : g_mid
      assign nv = c_valid[i+1];
      assign nd = c_deadline[i+1];
      assign nh = c_handler[i+1];
    end

    aps_cell #(
      .HANDLER_BITS(HANDLER_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .hole_in      (hole[i]),
      .hole_out     (hole[i+1]),
      .prev_valid   (pv),
      .prev_deadline(pd),
      .prev_handler (ph),
      .next_valid   (nv),
      .next_deadline(nd),
      .next_handler (nh),
      .valid        (c_valid[i]),
      .deadline     (c_deadline[i]),
      .handler      (c_handler[i])
    );
  end

  // Sequencer, time and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_time   <= '0;
      pending    <= '0;
      step       <= '0;
      held_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (command.action == ACT_ADD) begin
              done <= 1'b1;
              if (!pool_full) begin
                pending <= pending + COUNT_W'(1);
              end
            end else begin
              cur_time   <= cur_time + 32'(command.elapsed);
              step       <= '0;
              held_valid <= 1'b0;
              state      <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          step <= step + STEP_W'(1);
          if (expire) begin
            pending    <= pending_dec;
            held_valid <= 1'b1;
            done       <= held_valid;
          end
          if (step == STEP_W'(MAX_ALARMS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Held fired alarm, released once the next one is found or the walk ends
  always_ff @(posedge clk) begin
    if (state == ST_WALK && expire) begin
      held_handler <= c_handler[0];
      held_count   <= pending_dec;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        result.kind          <= pool_full ? KIND_REJECT : KIND_ADD_OK;
        result.fired_handler <= zero_cnt_dummy[7:0];
        result.active_count  <= pool_full ? 4'(pending) : 4'(pending + COUNT_W'(1));
        result.last          <= 1'b1;
      end
      ST_WALK: begin
        result.kind          <= KIND_FIRED;
        result.fired_handler <= held_wide[7:0];
        result.active_count  <= 4'(held_count);
        result.last          <= 1'b0;
      end
      ST_FINISH: begin
        result.kind          <= held_valid ? KIND_FIRED : KIND_NONE;
        result.fired_handler <= held_valid ? held_wide[7:0] : zero_cnt_dummy[7:0];
        result.active_count  <= held_valid ? 4'(held_count) : 4'(pending);
        result.last          <= 1'b1;
      end
      default: begin
        result <= '0;
      end
    endcase
  end

endmodule

FILE: hdl/aps_checker.sv
module aps_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input aps_pkg::cmd_t command,
  input logic          done,
  input aps_pkg::res_t result
);
  import aps_pkg::*;

  // An accepted add answers with a single closing beat next cycle
  a_add_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.action == ACT_ADD) |=>
      (done && result.last &&
       (result.kind == KIND_ADD_OK || result.kind == KIND_REJECT)))
    else $error("add command not answered next cycle");

  // An accepted tick holds the command side off
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.action == ACT_TICK) |=> busy)
    else $error("tick accepted without going busy");

  // The closing beat of a tick shows with the command side released
  a_tick_release: assert property (@(posedge clk) disable iff (rst)
    (done && result.last &&
     (result.kind == KIND_FIRED || result.kind == KIND_NONE)) |-> !busy)
    else $error("busy held during the final tick beat");

  // A none beat carries no handler and closes the tick
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_NONE) |->
      (result.last && result.fired_handler == 8'd0))
    else $error("malformed none beat");

endmodule

bind alarm_pool_scheduler aps_checker u_aps_checker (.*);
